// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// Both take the clock and reset of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// A condition that must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define CHK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define CHK_ALWAYS(label, cond, msg)
`define CHK_NEXT(label, pre, post, msg)

`endif

`endif

// ===== rtl/fwtls_pkg.sv =====
package fwtls_pkg;

  // Default parameter values.
  localparam int ADC_BITS_DEF  = 10;
  localparam int TIME_BITS_DEF = 4;

  // Register widths.
  localparam int THR_BITS       = 10;
  localparam int DUR_BITS       = 4;
  localparam int CFG_DATA_BITS  = THR_BITS;
  localparam int CFG_INDEX_BITS = 3;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_THR     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NSG_DAY = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EWG_DAY = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NSG_NGT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EWG_NGT = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EWL     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NSL     = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_YEL     = 3'd7;

  // Register reset values.
  localparam logic [THR_BITS-1:0] RST_THR     = 10'd512;
  localparam logic [DUR_BITS-1:0] RST_NSG_DAY = 4'd8;
  localparam logic [DUR_BITS-1:0] RST_EWG_DAY = 4'd7;
  localparam logic [DUR_BITS-1:0] RST_NSG_NGT = 4'd7;
  localparam logic [DUR_BITS-1:0] RST_EWG_NGT = 4'd6;
  localparam logic [DUR_BITS-1:0] RST_EWL     = 4'd7;
  localparam logic [DUR_BITS-1:0] RST_NSL     = 4'd8;
  localparam logic [DUR_BITS-1:0] RST_YEL     = 4'd3;

  // Pedestrian countdown lengths in seconds.
  localparam logic [DUR_BITS-1:0] NS_WALK_SECONDS = 4'd9;
  localparam logic [DUR_BITS-1:0] EW_WALK_SECONDS = 4'd8;

  // Light colour codes.
  localparam logic [1:0] COL_OFF    = 2'd0;
  localparam logic [1:0] COL_RED    = 2'd1;
  localparam logic [1:0] COL_GREEN  = 2'd2;
  localparam logic [1:0] COL_YELLOW = 2'd3;

  // Seven-segment patterns, active low.
  localparam logic [7:0] DIGIT_BLANK_DAY = 8'h7F;
  localparam logic [7:0] DIGIT_OFF_NGT   = 8'hFF;

  // Number of request switches carried with each tick.
  localparam int REQ_BITS = 4;

  typedef enum logic [3:0] {
    PH_START,
    PH_NS_WALK,
    PH_NS_GREEN,
    PH_NS_YELLOW,
    PH_EWL_GREEN,
    PH_EWL_YELLOW,
    PH_EW_WALK,
    PH_EW_GREEN,
    PH_EW_YELLOW,
    PH_NSL_GREEN,
    PH_NSL_YELLOW
  } phase_t;

  // Configuration register file.
  typedef struct packed {
    logic [THR_BITS-1:0] night_threshold;
    logic [DUR_BITS-1:0] ns_green_day;
    logic [DUR_BITS-1:0] ew_green_day;
    logic [DUR_BITS-1:0] ns_green_night;
    logic [DUR_BITS-1:0] ew_green_night;
    logic [DUR_BITS-1:0] ew_left_green;
    logic [DUR_BITS-1:0] ns_left_green;
    logic [DUR_BITS-1:0] yellow_seconds;
  } cfg_t;

  // Request switches, first field in the highest bit.
  typedef struct packed {
    logic ew_walk_request;
    logic ew_left_request;
    logic ns_walk_request;
    logic ns_left_request;
  } req_t;

  // Sequencer control state other than the seconds count.
  typedef struct packed {
    phase_t phase;
    logic   half_flag;
    logic   is_night;
  } ctrl_t;

  // One result, first field in the highest bits.
  typedef struct packed {
    logic       buzzer_on;
    logic       second_led;
    logic [7:0] lower_segments;
    logic [7:0] upper_segments;
    logic [1:0] ew_left_colour;
    logic [1:0] ew_colour;
    logic [1:0] ns_left_colour;
    logic [1:0] ns_colour;
  } res_t;

  localparam int RES_BITS = $bits(res_t);

  // Segment pattern for a decimal digit; anything else shows blank.
  function automatic logic [7:0] digit_code(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'd0:    c = 8'h40;
      4'd1:    c = 8'h79;
      4'd2:    c = 8'h24;
      4'd3:    c = 8'h30;
      4'd4:    c = 8'h19;
      4'd5:    c = 8'h12;
      4'd6:    c = 8'h02;
      4'd7:    c = 8'h78;
      4'd8:    c = 8'h00;
      4'd9:    c = 8'h10;
      default: c = DIGIT_BLANK_DAY;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/fwtls_step.sv =====
module fwtls_step
  import fwtls_pkg::*;
#(
  parameter int ADC_BITS  = ADC_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  cfg_t                 cfg,
  input  ctrl_t                ctrl,
  input  logic [TIME_BITS-1:0] seconds_left,
  input  logic [ADC_BITS-1:0]  light_level,
  input  req_t                 req,
  output ctrl_t                ctrl_next,
  output logic [TIME_BITS-1:0] seconds_left_next,
  output res_t                 res
);

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam int CMP_W = (TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS;
  localparam int ADC_W = (ADC_BITS > THR_BITS) ? ADC_BITS : THR_BITS;
  localparam int DIG_W = (TIME_BITS > 4) ? TIME_BITS : 4;

  // A zero duration counts as one second; a long one saturates.
  function automatic logic [TIME_BITS-1:0] load_time(input logic [DUR_BITS-1:0] v);
    logic [CMP_W-1:0] ve;
    logic [TIME_BITS-1:0] t;
    ve = CMP_W'(v);
    if (v == '0) begin
      t = TIME_BITS'(1);
    end else if (ve > CMP_W'(TIME_MAX)) begin
      t = TIME_MAX;
    end else begin
      t = TIME_BITS'(ve);
    end
    return t;
  endfunction

  phase_t               phase_cur;
  logic                 night_cur;
  logic [TIME_BITS-1:0] secs_cur;
  logic                 walk_active;
  logic [DIG_W-1:0]     count;
  logic [7:0]           walk_code;
  logic [7:0]           blank;

  // Phase advance, with skipped optional phases resolved on the same tick.
  always_comb begin
    logic                cyc_night;
    logic                go_cycle;
    logic                go_ew;
    phase_t              ph;
    logic [DUR_BITS-1:0] dur;
    cyc_night = ADC_W'(light_level) > ADC_W'(cfg.night_threshold);
    go_cycle  = 1'b0;
    go_ew     = 1'b0;
    ph        = ctrl.phase;
    dur       = cfg.yellow_seconds;
    night_cur = ctrl.is_night;
    case (ctrl.phase)
      PH_NS_WALK: begin
        ph  = PH_NS_GREEN;
        dur = cfg.ns_green_day;
      end
      PH_NS_GREEN:  ph = PH_NS_YELLOW;
      PH_NS_YELLOW: begin
        if (req.ew_left_request) begin
          ph  = PH_EWL_GREEN;
          dur = cfg.ew_left_green;
        end else begin
          go_ew = 1'b1;
        end
      end
      PH_EWL_GREEN:  ph = PH_EWL_YELLOW;
      PH_EWL_YELLOW: go_ew = 1'b1;
      PH_EW_WALK: begin
        ph  = PH_EW_GREEN;
        dur = cfg.ew_green_day;
      end
      PH_EW_GREEN:  ph = PH_EW_YELLOW;
      PH_EW_YELLOW: begin
        if (req.ns_left_request) begin
          ph  = PH_NSL_GREEN;
          dur = cfg.ns_left_green;
        end else begin
          go_cycle = 1'b1;
        end
      end
      PH_NSL_GREEN: ph = PH_NSL_YELLOW;
      default:      go_cycle = 1'b1;
    endcase
    if (go_ew) begin
      if (!ctrl.is_night && req.ew_walk_request) begin
        ph  = PH_EW_WALK;
        dur = EW_WALK_SECONDS;
      end else begin
        ph  = PH_EW_GREEN;
        dur = ctrl.is_night ? cfg.ew_green_night : cfg.ew_green_day;
      end
    end
    if (go_cycle) begin
      if (!cyc_night && req.ns_walk_request) begin
        ph  = PH_NS_WALK;
        dur = NS_WALK_SECONDS;
      end else begin
        ph  = PH_NS_GREEN;
        dur = cyc_night ? cfg.ns_green_night : cfg.ns_green_day;
      end
    end

    if (!ctrl.half_flag && seconds_left == '0) begin
      phase_cur = ph;
      secs_cur  = load_time(dur);
      if (go_cycle) begin
        night_cur = cyc_night;
      end
    end else begin
      phase_cur = ctrl.phase;
      secs_cur  = seconds_left;
    end
  end

  // Seconds count down at the end of each second; the half flag toggles.
  always_comb begin
    ctrl_next.phase     = phase_cur;
    ctrl_next.is_night  = night_cur;
    ctrl_next.half_flag = !ctrl.half_flag;
    if (ctrl.half_flag && secs_cur != '0) begin
      seconds_left_next = secs_cur - TIME_BITS'(1);
    end else begin
      seconds_left_next = secs_cur;
    end
  end

  // Countdown digit for a pedestrian phase.
  assign walk_active = (phase_cur == PH_NS_WALK) || (phase_cur == PH_EW_WALK);
  assign count       = (secs_cur != '0) ? DIG_W'(secs_cur - TIME_BITS'(1)) : '0;
  assign walk_code   = (count >= DIG_W'(1) && count <= DIG_W'(9)) ?
                       digit_code(count[3:0]) : DIGIT_BLANK_DAY;
  assign blank       = night_cur ? DIGIT_OFF_NGT : DIGIT_BLANK_DAY;

  // Light colours from the current phase.
  always_comb begin
    res.ns_colour      = COL_RED;
    res.ns_left_colour = COL_RED;
    res.ew_colour      = COL_RED;
    res.ew_left_colour = COL_RED;
    case (phase_cur)
      PH_NS_WALK, PH_NS_GREEN: res.ns_colour      = COL_GREEN;
      PH_NS_YELLOW:            res.ns_colour      = COL_YELLOW;
      PH_EWL_GREEN:            res.ew_left_colour = COL_GREEN;
      PH_EWL_YELLOW:           res.ew_left_colour = COL_YELLOW;
      PH_EW_WALK, PH_EW_GREEN: res.ew_colour      = COL_GREEN;
      PH_EW_YELLOW:            res.ew_colour      = COL_YELLOW;
      PH_NSL_GREEN:            res.ns_left_colour = COL_GREEN;
      PH_NSL_YELLOW:           res.ns_left_colour = COL_YELLOW;
      default:                 res.ns_colour      = COL_RED;
    endcase
  end

  // Digits, second LED and buzzer.
  always_comb begin
    if (walk_active) begin
      res.upper_segments = (phase_cur == PH_NS_WALK) ? walk_code : DIGIT_BLANK_DAY;
      res.lower_segments = (phase_cur == PH_NS_WALK) ? DIGIT_BLANK_DAY : walk_code;
      res.second_led     = !ctrl.half_flag;
      res.buzzer_on      = !ctrl.half_flag;
    end else begin
      res.upper_segments = blank;
      res.lower_segments = blank;
      res.second_led     = ctrl.half_flag;
      res.buzzer_on      = 1'b0;
    end
  end

endmodule

// ===== rtl/four_way_traffic_light_sequencer_top.sv =====
// Channel   Direction  Width                 Contents
// s_axis    in         ceil((ADC_BITS+4)/8)*8 one half-second tick with sensor code and switches
// m_axis    out        32                    light colours, both digits, LED and buzzer
// cfg       in         10                    register writes, index 0 to 7
//
// One request is taken every clock cycle unless the output is stalled; its
// result appears in the output register on the next cycle. The whole phase
// step is one pass of logic between the state registers and the output register.
// Reset is synchronous and puts the sequencer at the start of a new cycle.
// A stalled output holds its result and blocks new requests until taken.
`include "assert_macros.svh"

module four_way_traffic_light_sequencer_top
  import fwtls_pkg::*;
#(
  parameter int ADC_BITS  = ADC_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  localparam int IN_TDATA_BITS  = ((ADC_BITS + REQ_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_BITS = ((RES_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // light_level, ns_left_request, ns_walk_request, ew_left_request,
  // ew_walk_request, zero fill
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // ns_colour, ns_left_colour, ew_colour, ew_left_colour, upper_segments,
  // lower_segments, second_led, buzzer_on, zero fill
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t                 cfg;
  ctrl_t                ctrl;
  ctrl_t                ctrl_next;
  logic [TIME_BITS-1:0] seconds_left;
  logic [TIME_BITS-1:0] seconds_left_next;
  logic [ADC_BITS-1:0]  light_level;
  req_t                 req;
  res_t                 res;
  logic                 accept;
  logic                 secs_running;
  logic                 walk_phase;
  logic                 out_stalled;

  assign light_level   = s_axis_tdata[ADC_BITS-1:0];
  assign req           = s_axis_tdata[ADC_BITS +: REQ_BITS];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.night_threshold <= RST_THR;
      cfg.ns_green_day    <= RST_NSG_DAY;
      cfg.ew_green_day    <= RST_EWG_DAY;
      cfg.ns_green_night  <= RST_NSG_NGT;
      cfg.ew_green_night  <= RST_EWG_NGT;
      cfg.ew_left_green   <= RST_EWL;
      cfg.ns_left_green   <= RST_NSL;
      cfg.yellow_seconds  <= RST_YEL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THR:     cfg.night_threshold <= cfg_data;
        REG_NSG_DAY: cfg.ns_green_day    <= cfg_data[DUR_BITS-1:0];
        REG_EWG_DAY: cfg.ew_green_day    <= cfg_data[DUR_BITS-1:0];
        REG_NSG_NGT: cfg.ns_green_night  <= cfg_data[DUR_BITS-1:0];
        REG_EWG_NGT: cfg.ew_green_night  <= cfg_data[DUR_BITS-1:0];
        REG_EWL:     cfg.ew_left_green   <= cfg_data[DUR_BITS-1:0];
        REG_NSL:     cfg.ns_left_green   <= cfg_data[DUR_BITS-1:0];
        REG_YEL:     cfg.yellow_seconds  <= cfg_data[DUR_BITS-1:0];
        default:     cfg.yellow_seconds  <= cfg.yellow_seconds;
      endcase
    end
  end

  // Phase step for one tick.
  fwtls_step #(
    .ADC_BITS  (ADC_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .cfg               (cfg),
    .ctrl              (ctrl),
    .seconds_left      (seconds_left),
    .light_level       (light_level),
    .req               (req),
    .ctrl_next         (ctrl_next),
    .seconds_left_next (seconds_left_next),
    .res               (res)
  );

  // Sequencer state moves on with each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase     <= PH_START;
      ctrl.half_flag <= 1'b0;
      ctrl.is_night  <= 1'b0;
      seconds_left   <= '0;
    end else if (accept) begin
      ctrl         <= ctrl_next;
      seconds_left <= seconds_left_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= OUT_TDATA_BITS'(res);
    end
  end

  // Conditions watched by the checks below.
  assign secs_running = (seconds_left != '0) && (ctrl.phase != PH_START);
  assign walk_phase   = (ctrl.phase == PH_NS_WALK) || (ctrl.phase == PH_EW_WALK);
  assign out_stalled  = m_axis_tvalid && !m_axis_tready;

  `CHK_NEXT(a_half_toggles, accept, ctrl.half_flag != $past(ctrl.half_flag), "half flag stuck")
  `CHK_NEXT(a_result_follows, accept, m_axis_tvalid, "accepted request gave no result")
  `CHK_ALWAYS(a_half_timed, !ctrl.half_flag || secs_running, "second half with no time left")
  `CHK_ALWAYS(a_walk_day_only, !walk_phase || !ctrl.is_night, "countdown at night")
  `CHK_ALWAYS(a_stall_blocks_input, !out_stalled || !s_axis_tready, "input open while stalled")

endmodule
